/* hw/rtl/go_to_goal_p_controller_macros.svh */
// assertion macros for the go-to-goal controller
`ifndef GO_TO_GOAL_P_CONTROLLER_MACROS_SVH
`define GO_TO_GOAL_P_CONTROLLER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GGPC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition must never hold
`define GGPC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/ggpc_pkg.sv */
// shared widths, constants, register indexes and stage payload for the go-to-goal controller
`default_nettype none
package ggpc_pkg;

	localparam int POS_W      = 16;
	localparam int DIFF_W     = 17;
	localparam int MAG_W      = 16;
	localparam int GAIN_W     = 12;
	localparam int SPEED_W    = 15;
	localparam int TURN_W     = 16;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	// cordic datapath
	localparam int CW       = 28;
	localparam int AW       = 24;
	localparam int ATAN_LEN = 24;
	localparam logic signed [AW-1:0] HALF_PI = AW'(1647099);

	// restoring square root of gain^2 * (dx^2 + dy^2)
	localparam int PROD_SQ_W  = 2 * (GAIN_W + MAG_W);
	localparam int RAD_W      = 58;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int LIN_W      = ROOT_W - 11;

	// turn rate product and rounding
	localparam int PROD_W = AW + GAIN_W + 1;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(524288);
	localparam logic signed [PROD_W-1:0] TURN_MAX   = PROD_W'(32767);
	localparam logic signed [PROD_W-1:0] TURN_MIN   = -(PROD_W'(32768));

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_GOAL_X         = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_GOAL_Y         = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_STOP_TOLERANCE = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_LINEAR_GAIN    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_ANGULAR_GAIN   = 3'd4;

	typedef struct packed {
		logic                    arrived;
		logic                    zero;
		logic signed [POS_W-1:0] heading;
		logic signed [CW-1:0]    cx;
		logic signed [CW-1:0]    cy;
		logic signed [AW-1:0]    acc;
		logic [RAD_W-1:0]        rad;
		logic [REM_W-1:0]        rem;
		logic [ROOT_W-1:0]       root;
	} ggpc_step_t;

	// round(atan(2^-i) * 2^20)
	function automatic logic signed [AW-1:0] atan_entry(input int idx);
		logic signed [AW-1:0] v;
		case (idx)
			0:  v = AW'(823550);
			1:  v = AW'(486170);
			2:  v = AW'(256879);
			3:  v = AW'(130396);
			4:  v = AW'(65451);
			5:  v = AW'(32757);
			6:  v = AW'(16383);
			7:  v = AW'(8192);
			8:  v = AW'(4096);
			9:  v = AW'(2048);
			10: v = AW'(1024);
			11: v = AW'(512);
			12: v = AW'(256);
			13: v = AW'(128);
			14: v = AW'(64);
			15: v = AW'(32);
			16: v = AW'(16);
			17: v = AW'(8);
			18: v = AW'(4);
			19: v = AW'(2);
			20: v = AW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/ggpc_front.sv */
// front stages: differences, squares, tolerance test, radicand and cordic pre-rotation
`default_nettype none
module ggpc_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic                            in_beat,
	input  wire logic signed [ggpc_pkg::POS_W-1:0] pose_x,
	input  wire logic signed [ggpc_pkg::POS_W-1:0] pose_y,
	input  wire logic signed [ggpc_pkg::POS_W-1:0] pose_heading,
	input  wire logic signed [ggpc_pkg::POS_W-1:0] goal_x,
	input  wire logic signed [ggpc_pkg::POS_W-1:0] goal_y,
	input  wire logic [ggpc_pkg::MAG_W-1:0]        stop_tolerance,
	input  wire logic [ggpc_pkg::GAIN_W-1:0]       linear_gain,
	output logic                                   valid_o,
	output ggpc_pkg::ggpc_step_t                   data_o
);
	import ggpc_pkg::*;

	logic signed [DIFF_W-1:0] dx_c, dy_c;

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic [MAG_W-1:0]         adx_s1, ady_s1;
	logic signed [POS_W-1:0]  head_s1, head_s2, head_s3;
	logic [2*MAG_W-1:0]       xx_s2, yy_s2, tt_s2;
	logic [GAIN_W+MAG_W-1:0]  px_s2, py_s2;
	logic                     zero_s2, zero_s3;
	logic                     arr_s3;
	logic [PROD_SQ_W-1:0]     pxx_s3, pyy_s3;
	ggpc_step_t               step_s4;

	logic signed [CW-1:0]     x0_c, y0_c;

	assign dx_c = DIFF_W'(goal_x) - DIFF_W'(pose_x);
	assign dy_c = DIFF_W'(goal_y) - DIFF_W'(pose_y);

	assign x0_c = {{(CW-DIFF_W-8){dx_s3[DIFF_W-1]}}, dx_s3, 8'b0};
	assign y0_c = {{(CW-DIFF_W-8){dy_s3[DIFF_W-1]}}, dy_s3, 8'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_beat;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: differences and magnitudes
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;
			adx_s1  <= dx_c[DIFF_W-1] ? MAG_W'(-dx_c) : MAG_W'(dx_c);
			ady_s1  <= dy_c[DIFF_W-1] ? MAG_W'(-dy_c) : MAG_W'(dy_c);
			head_s1 <= pose_heading;
			// s2: squares and gain products
			xx_s2   <= adx_s1 * adx_s1;
			yy_s2   <= ady_s1 * ady_s1;
			tt_s2   <= stop_tolerance * stop_tolerance;
			px_s2   <= linear_gain * adx_s1;
			py_s2   <= linear_gain * ady_s1;
			zero_s2 <= (adx_s1 == '0) && (ady_s1 == '0);
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			head_s2 <= head_s1;
			// s3: tolerance test and scaled squares
			arr_s3  <= ({1'b0, xx_s2} + {1'b0, yy_s2}) < {1'b0, tt_s2};
			pxx_s3  <= px_s2 * px_s2;
			pyy_s3  <= py_s2 * py_s2;
			zero_s3 <= zero_s2;
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			head_s3 <= head_s2;
			// s4: radicand and quarter-turn pre-rotation
			step_s4.arrived <= arr_s3;
			step_s4.zero    <= zero_s3;
			step_s4.heading <= head_s3;
			step_s4.rad     <= RAD_W'(pxx_s3) + RAD_W'(pyy_s3);
			step_s4.rem     <= '0;
			step_s4.root    <= '0;
			if (dx_s3[DIFF_W-1]) begin
				if (!dy_s3[DIFF_W-1]) begin
					step_s4.cx  <= y0_c;
					step_s4.cy  <= -x0_c;
					step_s4.acc <= HALF_PI;
				end else begin
					step_s4.cx  <= -y0_c;
					step_s4.cy  <= x0_c;
					step_s4.acc <= -HALF_PI;
				end
			end else begin
				step_s4.cx  <= x0_c;
				step_s4.cy  <= y0_c;
				step_s4.acc <= '0;
			end
		end
	end

	assign valid_o = v_s4;
	assign data_o  = step_s4;

endmodule
`default_nettype wire

/* hw/rtl/ggpc_step.sv */
// one pipeline stage: one square root digit and one cordic vectoring rotation, each only while STEP is within its count
`default_nettype none
module ggpc_step #(
	parameter int STEP          = 0,
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 valid_i,
	input  wire ggpc_pkg::ggpc_step_t data_i,
	output logic                      valid_o,
	output ggpc_pkg::ggpc_step_t      data_o
);
	import ggpc_pkg::*;

	ggpc_step_t nxt;
	logic       v_s1;
	ggpc_step_t step_s1;

	always_comb begin
		nxt = data_i;
		if (STEP < SQRT_STEPS) begin
			logic [REM_W+1:0] cand, trial;
			cand  = {data_i.rem, data_i.rad[RAD_W-1 -: 2]};
			trial = {{(REM_W-ROOT_W){1'b0}}, data_i.root, 2'b01};
			nxt.rad = data_i.rad << 2;
			if (cand >= trial) begin
				nxt.rem  = REM_W'(cand - trial);
				nxt.root = {data_i.root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem  = REM_W'(cand);
				nxt.root = {data_i.root[ROOT_W-2:0], 1'b0};
			end
		end
		if ((STEP < CORDIC_STAGES) && (STEP < ATAN_LEN)) begin
			logic signed [CW-1:0] xs, ys;
			xs = data_i.cx >>> STEP;
			ys = data_i.cy >>> STEP;
			if (data_i.cy > 0) begin
				nxt.cx  = data_i.cx + ys;
				nxt.cy  = data_i.cy - xs;
				nxt.acc = data_i.acc + atan_entry(STEP);
			end else begin
				nxt.cx  = data_i.cx - ys;
				nxt.cy  = data_i.cy + xs;
				nxt.acc = data_i.acc - atan_entry(STEP);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s1 <= nxt;
		end
	end

	assign valid_o = v_s1;
	assign data_o  = step_s1;

endmodule
`default_nettype wire

/* hw/rtl/ggpc_back.sv */
// back stages: heading error, gain product, rounding, saturation and output register
`default_nettype none
module ggpc_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic                                valid_i,
	input  wire ggpc_pkg::ggpc_step_t                data_i,
	input  wire logic [ggpc_pkg::GAIN_W-1:0]         angular_gain,
	output logic                                     valid_o,
	output logic [ggpc_pkg::SPEED_W-1:0]             linear_speed,
	output logic signed [ggpc_pkg::TURN_W-1:0]       turn_rate,
	output logic                                     arrived
);
	import ggpc_pkg::*;

	logic signed [AW-1:0]     bearing_c, head_c;
	logic [LIN_W-1:0]         lin_c;
	logic signed [PROD_W-1:0] shifted_c;

	logic                     v_s1, v_s2, v_s3;
	logic signed [AW-1:0]     err_s1;
	logic [SPEED_W-1:0]       speed_s1, speed_s2, speed_s3;
	logic                     arr_s1, arr_s2, arr_s3;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [TURN_W-1:0] turn_s3;

	assign bearing_c = data_i.zero ? '0 : data_i.acc;
	assign head_c    = {{(AW-POS_W-7){data_i.heading[POS_W-1]}}, data_i.heading, 7'b0};
	assign lin_c     = LIN_W'(data_i.root >> 11);
	assign shifted_c = (prod_s2 + ROUND_HALF) >>> 20;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s1   <= bearing_c - head_c;
			speed_s1 <= (lin_c[LIN_W-1:SPEED_W] != '0) ? '1 : lin_c[SPEED_W-1:0];
			arr_s1   <= data_i.arrived;
			prod_s2  <= $signed({1'b0, angular_gain}) * err_s1;
			speed_s2 <= speed_s1;
			arr_s2   <= arr_s1;
			arr_s3   <= arr_s2;
			if (arr_s2) begin
				speed_s3 <= '0;
				turn_s3  <= '0;
			end else begin
				speed_s3 <= speed_s2;
				if (shifted_c > TURN_MAX) begin
					turn_s3 <= TURN_MAX[TURN_W-1:0];
				end else if (shifted_c < TURN_MIN) begin
					turn_s3 <= TURN_MIN[TURN_W-1:0];
				end else begin
					turn_s3 <= shifted_c[TURN_W-1:0];
				end
			end
		end
	end

	assign valid_o      = v_s3;
	assign linear_speed = speed_s3;
	assign turn_rate    = turn_s3;
	assign arrived      = arr_s3;

endmodule
`default_nettype wire

/* hw/rtl/go_to_goal_p_controller.sv */
// top level of the go-to-goal proportional controller: registers, pipeline chain, checks
//
//  channel  direction  handshake               payload
//  in       sink       in_valid / in_ready     pose_x, pose_y, pose_heading
//  out      source     out_valid / out_ready   linear_speed, turn_rate, arrived
//  cfg      sink       cfg_wr_en               cfg_addr, cfg_wdata
//
// one beat enters per cycle unless the output stalls; the step chain is as long as the larger
// of the 29 digit stages of the square root and the CORDIC_STAGES rotations, which run side by side
// reset clears every valid bit and loads the register defaults; no clearing pass
// the whole pipeline holds while the output register is full and out_ready is low
`default_nettype none
`include "go_to_goal_p_controller_macros.svh"
module go_to_goal_p_controller #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [ggpc_pkg::POS_W-1:0]     pose_x,
	input  wire logic signed [ggpc_pkg::POS_W-1:0]     pose_y,
	input  wire logic signed [ggpc_pkg::POS_W-1:0]     pose_heading,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [ggpc_pkg::SPEED_W-1:0]               linear_speed,
	output logic signed [ggpc_pkg::TURN_W-1:0]         turn_rate,
	output logic                                       arrived,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [ggpc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  wire logic [ggpc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import ggpc_pkg::*;

	localparam int STEPS = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

	logic signed [POS_W-1:0] goal_x_q, goal_y_q;
	logic [MAG_W-1:0]        stop_tolerance_q;
	logic [GAIN_W-1:0]       linear_gain_q, angular_gain_q;

	logic       en;
	logic       chain_v [0:STEPS];
	ggpc_step_t chain_d [0:STEPS];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q         <= '0;
			goal_y_q         <= '0;
			stop_tolerance_q <= MAG_W'(205);
			linear_gain_q    <= GAIN_W'(384);
			angular_gain_q   <= GAIN_W'(1536);
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_GOAL_X:         goal_x_q         <= cfg_wdata;
				REG_GOAL_Y:         goal_y_q         <= cfg_wdata;
				REG_STOP_TOLERANCE: stop_tolerance_q <= cfg_wdata;
				REG_LINEAR_GAIN:    linear_gain_q    <= cfg_wdata[GAIN_W-1:0];
				REG_ANGULAR_GAIN:   angular_gain_q   <= cfg_wdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline advances whenever the output register can take a beat
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	ggpc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_beat        (in_valid && in_ready),
		.pose_x         (pose_x),
		.pose_y         (pose_y),
		.pose_heading   (pose_heading),
		.goal_x         (goal_x_q),
		.goal_y         (goal_y_q),
		.stop_tolerance (stop_tolerance_q),
		.linear_gain    (linear_gain_q),
		.valid_o        (chain_v[0]),
		.data_o         (chain_d[0])
	);

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		ggpc_step #(
			.STEP          (k),
			.CORDIC_STAGES (CORDIC_STAGES)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (chain_v[k]),
			.data_i  (chain_d[k]),
			.valid_o (chain_v[k+1]),
			.data_o  (chain_d[k+1])
		);
	end

	ggpc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.valid_i      (chain_v[STEPS]),
		.data_i       (chain_d[STEPS]),
		.angular_gain (angular_gain_q),
		.valid_o      (out_valid),
		.linear_speed (linear_speed),
		.turn_rate    (turn_rate),
		.arrived      (arrived)
	);

	`GGPC_ASSERT_IMPLIES(a_stall_blocks_input, clk, arst_n, out_valid && !out_ready, !in_ready, "input taken while output stalled")
	`GGPC_ASSERT_IMPLIES(a_arrived_stops, clk, arst_n, out_valid && arrived, (linear_speed == '0) && (turn_rate == '0), "motion commanded after arrival")
	`GGPC_ASSERT_NEVER(a_ready_when_empty, clk, arst_n, !in_ready && !out_valid, "input refused with empty output register")

endmodule
`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for go_to_goal_p_controller: directed table, random poses, shadow predictor
module testbench;
	import ggpc_pkg::*;

	localparam int STAGES = 16;
	localparam longint QUARTER_TURN = 1647099;
	localparam int IDLE_PCT = 21;
	localparam int DRAIN_CYCLES = 48;
	localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;

	typedef struct packed {
		logic [SPEED_W-1:0]       speed;
		logic signed [TURN_W-1:0] turn;
		logic                     arrived;
	} command_t;

	typedef enum logic {STEP_POSE, STEP_REG} step_kind_t;

	typedef struct {
		step_kind_t              kind;
		logic [CFG_ADDR_W-1:0]   reg_idx;
		logic [CFG_DATA_W-1:0]   reg_val;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] heading;
		bit                      known;
		command_t                want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [POS_W-1:0] pose_x = '0;
	logic signed [POS_W-1:0] pose_y = '0;
	logic signed [POS_W-1:0] pose_heading = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SPEED_W-1:0] linear_speed;
	logic signed [TURN_W-1:0] turn_rate;
	logic arrived;
	logic cfg_wr_en = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// shadow of the configuration registers
	logic signed [POS_W-1:0] aim_x = '0;
	logic signed [POS_W-1:0] aim_y = '0;
	logic [15:0] tol_set = 16'd205;
	logic [GAIN_W-1:0] lin_gain_set = 12'd384;
	logic [GAIN_W-1:0] ang_gain_set = 12'd1536;

	longint atan_step [0:23] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
		4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

	command_t awaited_cmds [$];
	plan_row_t plan [$];
	bit known_active = 1'b0;
	command_t known_cmd = '0;
	bit steady = 1'b0;
	int mismatches = 0;
	int out_beats = 0;

	go_to_goal_p_controller #(.CORDIC_STAGES(STAGES)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pose_x(pose_x), .pose_y(pose_y), .pose_heading(pose_heading),
		.out_valid(out_valid), .out_ready(out_ready),
		.linear_speed(linear_speed), .turn_rate(turn_rate), .arrived(arrived),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#400000;
		$display("testbench: done, errors");
		$finish;
	end

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned res, probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v = v - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	// bearing in units of 2^-20 rad
	function automatic longint goal_bearing(input longint dx, input longint dy);
		longint x, y, acc, t, xs, ys;
		int n;
		if (dx == 0 && dy == 0)
			return 0;
		x = dx * 256;
		y = dy * 256;
		acc = 0;
		n = (STAGES > 24) ? 24 : STAGES;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				acc = QUARTER_TURN;
			end else begin
				x = -y;
				y = t;
				acc = -QUARTER_TURN;
			end
		end
		for (int i = 0; i < n; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				acc = acc + atan_step[i];
			end else begin
				x = x - ys;
				y = y + xs;
				acc = acc - atan_step[i];
			end
		end
		return acc;
	endfunction

	function automatic command_t steer_command(input logic signed [POS_W-1:0] px,
			input logic signed [POS_W-1:0] py, input logic signed [POS_W-1:0] ph);
		longint dx, dy, err, turn;
		longint unsigned sq, tol, lg, speed;
		command_t c;
		dx = longint'(aim_x) - longint'(px);
		dy = longint'(aim_y) - longint'(py);
		sq = longint'(dx * dx + dy * dy);
		tol = tol_set;
		lg = lin_gain_set;
		c = '0;
		if (sq >= tol * tol) begin
			speed = root_floor(lg * lg * sq) >> 11;
			err = goal_bearing(dx, dy) - longint'(ph) * 128;
			turn = (longint'(ang_gain_set) * err + 524288) >>> 20;
			if (speed > 32767)
				speed = 32767;
			if (turn > 32767)
				turn = 32767;
			if (turn < -32768)
				turn = -32768;
			c.speed = speed[SPEED_W-1:0];
			c.turn = turn[TURN_W-1:0];
		end else begin
			c.arrived = 1'b1;
		end
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch: %s", msg);
	endtask

	always @(posedge clk) begin
		command_t want;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_GOAL_X: aim_x = cfg_wdata;
					REG_GOAL_Y: aim_y = cfg_wdata;
					REG_STOP_TOLERANCE: tol_set = cfg_wdata;
					REG_LINEAR_GAIN: lin_gain_set = cfg_wdata[GAIN_W-1:0];
					REG_ANGULAR_GAIN: ang_gain_set = cfg_wdata[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				awaited_cmds.push_back(known_active ? known_cmd :
					steer_command(pose_x, pose_y, pose_heading));
			if (out_valid && out_ready) begin
				if (awaited_cmds.size() == 0) begin
					report_mismatch($sformatf("beat %0d arrived with nothing pending", out_beats));
				end else begin
					want = awaited_cmds.pop_front();
					if (linear_speed !== want.speed)
						report_mismatch($sformatf("beat %0d linear_speed %0d, expected %0d",
							out_beats, linear_speed, want.speed));
					if (turn_rate !== want.turn)
						report_mismatch($sformatf("beat %0d turn_rate %0d, expected %0d",
							out_beats, turn_rate, want.turn));
					if (arrived !== want.arrived)
						report_mismatch($sformatf("beat %0d arrived %0b, expected %0b",
							out_beats, arrived, want.arrived));
				end
				out_beats++;
			end
		end
	end

	always @(negedge clk)
		out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

	task automatic send_pose(input logic signed [POS_W-1:0] px, input logic signed [POS_W-1:0] py,
			input logic signed [POS_W-1:0] ph, input bit known, input command_t want);
		cfg_wr_en <= 1'b0;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pose_x <= px;
		pose_y <= py;
		pose_heading <= ph;
		known_active = known;
		known_cmd = want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// registers change only once the pipeline has drained
	task automatic reg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		in_valid <= 1'b0;
		while (awaited_cmds.size() != 0)
			@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	function automatic plan_row_t pose_row(input int px, input int py, input int ph);
		plan_row_t r;
		r.kind = STEP_POSE;
		r.reg_idx = '0;
		r.reg_val = '0;
		r.x = POS_W'(px);
		r.y = POS_W'(py);
		r.heading = POS_W'(ph);
		r.known = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic plan_row_t known_row(input int px, input int py, input int ph,
			input int speed, input int turn, input bit stop);
		plan_row_t r;
		r = pose_row(px, py, ph);
		r.known = 1'b1;
		r.want.speed = SPEED_W'(speed);
		r.want.turn = TURN_W'(turn);
		r.want.arrived = stop;
		return r;
	endfunction

	function automatic plan_row_t reg_row(input logic [CFG_ADDR_W-1:0] idx, input int val);
		plan_row_t r;
		r = pose_row(0, 0, 0);
		r.kind = STEP_REG;
		r.reg_idx = idx;
		r.reg_val = CFG_DATA_W'(val);
		return r;
	endfunction

	function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return v[POS_W-1:0];
	endfunction

	task automatic setup_phase(input int phase);
		int tol, lg, ag;
		tol = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8191);
		lg = $urandom_range(0, 4095);
		ag = $urandom_range(0, 4095);
		case (phase)
			0: begin
				lg = 4095;
				ag = 4095;
			end
			1: begin
				tol = 0;
				lg = 1;
				ag = 1;
			end
			5: tol = 65535;
			default: ;
		endcase
		reg_write(REG_GOAL_X, (phase == 0) ? 16'h7FFF : (phase == 1) ? 16'h8000 : 16'($urandom()));
		reg_write(REG_GOAL_Y, (phase == 0) ? 16'h8000 : (phase == 1) ? 16'h7FFF : 16'($urandom()));
		reg_write(REG_STOP_TOLERANCE, CFG_DATA_W'(tol));
		reg_write(REG_LINEAR_GAIN, {4'($urandom()), 12'(lg)});
		reg_write(REG_ANGULAR_GAIN, {4'($urandom()), 12'(ag)});
		reg_write(REG_NONE, 16'($urandom()));
	endtask

	task automatic send_random_pose();
		int mode, reach;
		logic signed [POS_W-1:0] px, py, ph;
		mode = $urandom_range(0, 9);
		reach = (tol_set < 2) ? 2 : tol_set;
		ph = POS_W'(int'($urandom_range(0, 51472)) - 25736);
		if (mode < 3) begin
			px = clamp_pos(longint'(aim_x) + int'($urandom_range(0, 2 * reach)) - reach);
			py = clamp_pos(longint'(aim_y) + int'($urandom_range(0, 2 * reach)) - reach);
		end else if (mode == 3) begin
			px = aim_x;
			py = aim_y;
		end else begin
			px = 16'($urandom());
			py = 16'($urandom());
		end
		send_pose(px, py, ph, 1'b0, '0);
	endtask

	initial begin
		plan.push_back(known_row(0, 0, 0, 0, 0, 1));
		plan.push_back(known_row(100, -50, 8192, 0, 0, 1));
		plan.push_back(known_row(204, 0, -8192, 0, 0, 1));
		plan.push_back(pose_row(-205, 0, 0));
		plan.push_back(pose_row(0, 205, 25736));
		plan.push_back(pose_row(-32768, -32768, 25736));
		plan.push_back(pose_row(32767, 32767, -25736));
		plan.push_back(pose_row(32767, 0, 0));
		plan.push_back(pose_row(32767, 1, 25736));
		plan.push_back(pose_row(0, -32768, -25736));
		plan.push_back(reg_row(REG_NONE, 16'h0123));
		plan.push_back(known_row(100, 0, 0, 0, 0, 1));
		plan.push_back(reg_row(REG_GOAL_X, 32767));
		plan.push_back(reg_row(REG_GOAL_Y, -32768));
		plan.push_back(pose_row(-32768, 32767, 25736));
		plan.push_back(known_row(32767, -32768, -25736, 0, 0, 1));
		plan.push_back(reg_row(REG_LINEAR_GAIN, 16'hFFFF));
		plan.push_back(reg_row(REG_ANGULAR_GAIN, 16'hFFFF));
		plan.push_back(pose_row(-32768, 32767, -25736));
		plan.push_back(pose_row(-32768, -32768, 25736));
		// zero tolerance with the pose on the goal still drives
		plan.push_back(reg_row(REG_STOP_TOLERANCE, 0));
		plan.push_back(pose_row(32767, -32768, -25736));
		plan.push_back(reg_row(REG_LINEAR_GAIN, 16'h0000));
		plan.push_back(reg_row(REG_ANGULAR_GAIN, 16'hF000));
		plan.push_back(known_row(32767, -32768, 12345, 0, 0, 0));
		plan.push_back(known_row(0, 0, -25736, 0, 0, 0));
		plan.push_back(reg_row(REG_STOP_TOLERANCE, 65535));
		plan.push_back(known_row(-32768, 32767, 0, 0, 0, 0));
		plan.push_back(known_row(0, 0, 0, 0, 0, 1));

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_REG)
				reg_write(plan[i].reg_idx, plan[i].reg_val);
			else
				send_pose(plan[i].x, plan[i].y, plan[i].heading, plan[i].known, plan[i].want);
		end

		for (int phase = 0; phase < 8; phase++) begin
			setup_phase(phase);
			steady = (phase == 3);
			for (int n = 0; n < 116; n++)
				send_random_pose();
			steady = 1'b0;
		end

		in_valid <= 1'b0;
		cfg_wr_en <= 1'b0;
		while (awaited_cmds.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
